// ===== design/qtrk_pkg.sv =====
`default_nettype none

package qtrk_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_EDGE_A = 2'd0,
    CMD_EDGE_B = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_ZERO   = 2'd3
  } cmd_e;

  // Result kinds.
  localparam logic KIND_POSITION  = 1'b0;
  localparam logic KIND_DIRECTION = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_INTERVAL = 2'd1;

  // Interpolation phase codes.
  localparam logic [2:0] PHASE_CW       = 3'd0;
  localparam logic [2:0] PHASE_CW_HALF  = 3'd1;
  localparam logic [2:0] PHASE_CCW_HALF = 3'd2;
  localparam logic [2:0] PHASE_CCW      = 3'd3;
  localparam logic [2:0] PHASE_IDLE     = 3'd4;

  // Reset values of configuration and timing state.
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd64;
  localparam logic [15:0] MAX_INTERVAL_RST = 16'd30000;
  localparam logic [15:0] PERIOD_RST       = 16'd15000;

  // One result beat.
  typedef struct packed {
    logic        kind;
    logic [15:0] position;
    logic        clockwise;
    logic        last;
  } result_t;

  // Results produced by one input item, packed from slot 0.
  typedef struct packed {
    logic [1:0] count;
    result_t    slot1;
    result_t    slot0;
  } result_pair_t;

endpackage

`default_nettype wire

// ===== design/quadrature_tracker_with_interpolation.sv =====
`default_nettype none

// Channel  Handshake               Beat contents
// in       in_valid_i/in_stall_o   cmd, pin_a, pin_b
// out      out_valid_o/out_stall_i kind, position, clockwise, last
// cfg      cfg_valid_i/cfg_ready_o register index, 16-bit data
//
// One item is taken per cycle while in_stall_o is low; it is registered, then decoded in a single pass
// into zero, one or two result beats that enter a four-entry result queue.
// An accepted item passes through the input register and then a queue entry before its first beat is out.
// The output drains one beat per cycle while out_stall_i is low, so items that make two beats
// slow the input; in_stall_o rises when an item is held and the queue lacks two free slots.
// Asynchronous active-low reset restores the register defaults and idle phase.

module quadrature_tracker_with_interpolation #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       in_cmd_i,
  input  wire logic                             in_pin_a_i,
  input  wire logic                             in_pin_b_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  out_kind_o,
  output logic signed [15:0]                    out_position_o,
  output logic                                  out_clockwise_o,
  output logic                                  out_last_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [qtrk_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [15:0]                      cfg_data_i
);

  logic       vld_q;
  logic [1:0] cmd_q;
  logic       pin_a_q, pin_b_q;
  logic       room, step, accept;
  qtrk_pkg::result_pair_t res;
  qtrk_pkg::result_t      head;

  // Input register stage.
  assign step       = vld_q && room;
  assign in_stall_o = vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept || (vld_q && !step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_cmd_i;
      pin_a_q <= in_pin_a_i;
      pin_b_q <= in_pin_b_i;
    end
  end

  qtrk_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (cmd_q),
    .pin_a_i     (pin_a_q),
    .pin_b_i     (pin_b_q),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res)
  );

  qtrk_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (head)
  );

  assign out_kind_o      = head.kind;
  assign out_position_o  = head.position;
  assign out_clockwise_o = head.clockwise;
  assign out_last_o      = head.last;

endmodule

`default_nettype wire

// ===== design/qtrk_core.sv =====
`default_nettype none

module qtrk_core #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 step_i,
  input  wire logic [1:0]                           cmd_i,
  input  wire logic                                 pin_a_i,
  input  wire logic                                 pin_b_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [qtrk_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [15:0]                          cfg_data_i,
  output qtrk_pkg::result_pair_t                    res_o
);

  logic [15:0]               min_q, max_q;
  logic [POSITION_WIDTH-1:0] count_q, count_d;
  logic                      dir_q, dir_d;
  logic [2:0]                phase_q, phase_d;
  logic [15:0]               etimer_q, etimer_d;
  logic                      ovf_q, ovf_d;
  logic [15:0]               itimer_q, itimer_d;
  logic [15:0]               period_q, period_d;

  qtrk_pkg::cmd_e cmd;
  logic           cw;
  logic [15:0]    raised, interval, etimer_inc;
  logic [31:0]    count_ext;
  logic [15:0]    pos_new;
  qtrk_pkg::result_pair_t res;

  assign cmd = qtrk_pkg::cmd_e'(cmd_i);

  // Clamp the edge interval; an overflowed timer stands for the upper bound.
  always_comb begin
    raised   = (etimer_q < min_q) ? min_q : etimer_q;
    interval = ovf_q ? max_q : ((raised > max_q) ? max_q : raised);
  end

  assign etimer_inc = etimer_q + 16'd1;

  // Next state for the accepted item.
  always_comb begin
    count_d  = count_q;
    dir_d    = dir_q;
    phase_d  = phase_q;
    etimer_d = etimer_q;
    ovf_d    = ovf_q;
    itimer_d = itimer_q;
    period_d = period_q;
    cw       = (cmd == qtrk_pkg::CMD_EDGE_A) ? (pin_a_i == pin_b_i) : (pin_a_i != pin_b_i);
    unique case (cmd) inside
      qtrk_pkg::CMD_EDGE_A, qtrk_pkg::CMD_EDGE_B: begin
        count_d  = cw ? count_q + POSITION_WIDTH'(1) : count_q - POSITION_WIDTH'(1);
        dir_d    = cw;
        phase_d  = cw ? qtrk_pkg::PHASE_CW : qtrk_pkg::PHASE_CCW;
        etimer_d = '0;
        ovf_d    = 1'b0;
        itimer_d = '0;
        period_d = {1'b0, interval[15:1]};
      end
      qtrk_pkg::CMD_TICK: begin
        etimer_d = etimer_inc;
        if (etimer_inc == 16'd0) begin
          ovf_d = 1'b1;
        end
        if (itimer_q == period_q) begin
          itimer_d = '0;
          if (phase_q == qtrk_pkg::PHASE_CW) begin
            phase_d = qtrk_pkg::PHASE_CW_HALF;
          end else if (phase_q == qtrk_pkg::PHASE_CCW) begin
            phase_d = qtrk_pkg::PHASE_CCW_HALF;
          end
        end else begin
          itimer_d = itimer_q + 16'd1;
        end
      end
      qtrk_pkg::CMD_ZERO: begin
        count_d = '0;
        dir_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Reported position: sign-extended count times two plus bit 0 of the phase code.
  assign count_ext = 32'(signed'(count_d));
  assign pos_new   = {count_ext[14:0], phase_d[0]};

  // Result beats for the item.
  always_comb begin
    res                 = '0;
    res.slot0.kind      = qtrk_pkg::KIND_POSITION;
    res.slot0.position  = pos_new;
    res.slot0.clockwise = dir_d;
    res.slot0.last      = 1'b1;
    res.slot1           = res.slot0;
    case (cmd) inside
      qtrk_pkg::CMD_EDGE_A, qtrk_pkg::CMD_EDGE_B: begin
        if (dir_q != cw) begin
          res.count           = 2'd2;
          res.slot0.kind      = qtrk_pkg::KIND_DIRECTION;
          res.slot0.position  = '0;
          res.slot0.last      = 1'b0;
        end else begin
          res.count = 2'd1;
        end
      end
      qtrk_pkg::CMD_TICK: begin
        if (phase_d != phase_q) begin
          res.count = 2'd1;
        end
      end
      default: begin
      end
    endcase
    if (!step_i) begin
      res.count = 2'd0;
    end
  end

  assign res_o = res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= qtrk_pkg::MIN_INTERVAL_RST;
      max_q <= qtrk_pkg::MAX_INTERVAL_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == qtrk_pkg::REG_MIN_INTERVAL) begin
        min_q <= cfg_data_i;
      end else if (cfg_index_i == qtrk_pkg::REG_MAX_INTERVAL) begin
        max_q <= cfg_data_i;
      end
    end
  end

  // Tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      dir_q    <= 1'b0;
      phase_q  <= qtrk_pkg::PHASE_IDLE;
      etimer_q <= '0;
      ovf_q    <= 1'b0;
      itimer_q <= '0;
      period_q <= qtrk_pkg::PERIOD_RST;
    end else if (step_i) begin
      count_q  <= count_d;
      dir_q    <= dir_d;
      phase_q  <= phase_d;
      etimer_q <= etimer_d;
      ovf_q    <= ovf_d;
      itimer_q <= itimer_d;
      period_q <= period_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/qtrk_outq.sv =====
`default_nettype none

module qtrk_outq (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire qtrk_pkg::result_pair_t push_i,
  output logic                        room_o,
  output logic                        valid_o,
  input  wire logic                   stall_i,
  output qtrk_pkg::result_t           data_o
);

  localparam int unsigned Depth = 4;

  qtrk_pkg::result_t mem_q [Depth];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rptr_q];

  // Result storage; slot 0 goes first.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.slot0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_q + 2'd1] <= push_i.slot1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_i.count;
      rptr_q <= rptr_q + {1'b0, pop};
      cnt_q  <= cnt_q + {1'b0, push_i.count} - {2'b0, pop};
    end
  end

  // The queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overfilled");

  // Results are only pushed while two entries are free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (cnt_q <= 3'd2))
    else $error("push without room");

  // A lone pop lowers the level by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> (cnt_q == $past(cnt_q) - 3'd1))
    else $error("pop accounting broken");

endmodule

`default_nettype wire

// ===== tb/quadrature_tracker_with_interpolation_tb.sv =====
module quadrature_tracker_with_interpolation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    qtrk_pkg::cmd_e cmd;
    logic           pin_a;
    logic           pin_b;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Port signals of the block.
  logic           in_valid = 1'b0;
  logic           in_stall;
  qtrk_pkg::cmd_e in_cmd = qtrk_pkg::CMD_ZERO;
  logic           in_pin_a = 1'b0;
  logic           in_pin_b = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic           out_kind;
  logic signed [15:0] out_position;
  logic           out_clockwise;
  logic           out_last;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [qtrk_pkg::CfgIdxWidth-1:0] cfg_index = qtrk_pkg::REG_MIN_INTERVAL;
  logic [15:0]    cfg_data = '0;

  // Queues between the stimulus, the tracker model and the output checker.
  item_t             pending_items[$];
  qtrk_pkg::result_t expected_results[$];
  item_t             next_item;
  qtrk_pkg::result_t seen_beat;
  qtrk_pkg::result_t want_beat;

  // Shadow of the tracker state and its registers.
  logic [15:0] pos_count;
  logic        moving_cw;
  logic [2:0]  half_phase;
  logic [15:0] ticks_since_edge;
  logic        tick_wrapped;
  logic [15:0] half_timer;
  logic [15:0] half_period;
  logic [15:0] cfg_min;
  logic [15:0] cfg_max;

  // Run control and bookkeeping.
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  logic hold_off = 1'b0;
  int   mismatch_count = 0;
  int   beats_accepted = 0;
  int   results_checked = 0;
  int   direction_reports = 0;
  int   half_step_reports = 0;
  int   settings_applied = 0;
  int unsigned cycle_count = 0;

  quadrature_tracker_with_interpolation u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_cmd_i       (in_cmd),
    .in_pin_a_i     (in_pin_a),
    .in_pin_b_i     (in_pin_b),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_kind_o     (out_kind),
    .out_position_o (out_position),
    .out_clockwise_o(out_clockwise),
    .out_last_o     (out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Position report: count doubled plus bit 0 of the phase code, kept to 16 bits.
  function automatic qtrk_pkg::result_t make_report(logic kind, logic last);
    qtrk_pkg::result_t r;
    r.kind      = kind;
    r.position  = (kind == qtrk_pkg::KIND_DIRECTION) ? 16'd0 :
                  {pos_count[14:0], half_phase[0]};
    r.clockwise = moving_cw;
    r.last      = last;
    return r;
  endfunction

  // Advance the shadow tracker by one input beat and queue what it should emit.
  task automatic track_item(input qtrk_pkg::cmd_e cmd, input logic pin_a,
                            input logic pin_b);
    logic        cw;
    logic [15:0] span;
    case (cmd) inside
      qtrk_pkg::CMD_EDGE_A, qtrk_pkg::CMD_EDGE_B: begin
        cw = (cmd == qtrk_pkg::CMD_EDGE_A) ? (pin_a == pin_b) : (pin_a != pin_b);
        pos_count = cw ? pos_count + 16'd1 : pos_count - 16'd1;
        // The edge interval is clamped, or forced to the upper clamp after a wrap.
        span = ticks_since_edge;
        ticks_since_edge = '0;
        half_timer = '0;
        if (tick_wrapped) begin
          span = cfg_max;
          tick_wrapped = 1'b0;
        end else begin
          if (span < cfg_min) span = cfg_min;
          if (span > cfg_max) span = cfg_max;
        end
        half_period = span >> 1;
        half_phase = cw ? qtrk_pkg::PHASE_CW : qtrk_pkg::PHASE_CCW;
        if (moving_cw != cw) begin
          moving_cw = cw;
          expected_results.push_back(make_report(qtrk_pkg::KIND_DIRECTION, 1'b0));
          direction_reports++;
        end
        expected_results.push_back(make_report(qtrk_pkg::KIND_POSITION, 1'b1));
      end
      qtrk_pkg::CMD_TICK: begin
        ticks_since_edge = ticks_since_edge + 16'd1;
        if (ticks_since_edge == 16'd0) tick_wrapped = 1'b1;
        if (half_timer == half_period) begin
          half_timer = '0;
          // Only a fresh full step moves on to its half step, once.
          if (half_phase == qtrk_pkg::PHASE_CW || half_phase == qtrk_pkg::PHASE_CCW) begin
            half_phase = (half_phase == qtrk_pkg::PHASE_CW) ? qtrk_pkg::PHASE_CW_HALF
                                                            : qtrk_pkg::PHASE_CCW_HALF;
            expected_results.push_back(make_report(qtrk_pkg::KIND_POSITION, 1'b1));
            half_step_reports++;
          end
        end else begin
          half_timer = half_timer + 16'd1;
        end
      end
      default: begin
        pos_count = '0;
        moving_cw = 1'b0;
      end
    endcase
  endtask

  // Input driver: hold a stalled beat, otherwise offer the next pending item or idle.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_item(in_cmd, in_pin_a, in_pin_b);
        beats_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_cmd   <= next_item.cmd;
          in_pin_a <= next_item.pin_a;
          in_pin_b <= next_item.pin_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Output monitor: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_beat = '{kind: out_kind, position: out_position, clockwise: out_clockwise,
                      last: out_last};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat, expected none, actual %p", $time, seen_beat);
        end else begin
          want_beat = expected_results.pop_front();
          check_field("kind", want_beat.kind, seen_beat.kind);
          check_field("position", want_beat.position, seen_beat.position);
          check_field("clockwise", want_beat.clockwise, seen_beat.clockwise);
          check_field("last", want_beat.last, seen_beat.last);
          results_checked++;
        end
      end
      out_stall <= hold_off || ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats still expected", $time, expected_results.size());
      $display("quadrature_tracker_with_interpolation_tb: errors");
      $finish;
    end
  end

  task automatic push_item(input qtrk_pkg::cmd_e cmd, input logic pin_a, input logic pin_b);
    pending_items.push_back('{cmd: cmd, pin_a: pin_a, pin_b: pin_b});
  endtask

  task automatic write_reg(input logic [qtrk_pkg::CfgIdxWidth-1:0] idx,
                           input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == qtrk_pkg::REG_MIN_INTERVAL) cfg_min = value;
    else cfg_max = value;
  endtask

  // Program both clamps and the idling mix; called only while the block is idle.
  task automatic begin_phase(input logic [15:0] lo, input logic [15:0] hi,
                             input int sender_pct, input int receiver_pct);
    write_reg(qtrk_pkg::REG_MIN_INTERVAL, lo);
    write_reg(qtrk_pkg::REG_MAX_INTERVAL, hi);
    settings_applied++;
    @(negedge clk);
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Wait for every item to go in and every result to come out, then let the
  // pipeline run dry since ticks and zero commands leave no trace at the output.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Mostly edges in a direction that changes now and then, each followed by a
  // burst of ticks, with zero commands and arbitrary beats mixed in.
  task automatic gen_random(input int n_items, input int burst_max);
    int   added;
    int   roll;
    int   ticks;
    logic a;
    logic walk_cw;
    added = 0;
    walk_cw = 1'b1;
    while (added < n_items) begin
      roll = $urandom_range(0, 99);
      a = 1'($urandom_range(0, 1));
      if (roll < 5) begin
        push_item(qtrk_pkg::CMD_ZERO, a, 1'($urandom_range(0, 1)));
        added++;
      end else if (roll < 12) begin
        push_item(qtrk_pkg::cmd_e'($urandom_range(0, 3)), a, 1'($urandom_range(0, 1)));
        added++;
      end else begin
        if ($urandom_range(0, 99) < 20) walk_cw = !walk_cw;
        if ($urandom_range(0, 1)) push_item(qtrk_pkg::CMD_EDGE_A, a, walk_cw ? a : !a);
        else push_item(qtrk_pkg::CMD_EDGE_B, a, walk_cw ? !a : a);
        ticks = $urandom_range(0, burst_max);
        repeat (ticks) push_item(qtrk_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
        added += 1 + ticks;
      end
    end
  endtask

  initial begin
    pos_count = '0;
    moving_cw = 1'b0;
    half_phase = qtrk_pkg::PHASE_IDLE;
    ticks_since_edge = '0;
    tick_wrapped = 1'b0;
    half_timer = '0;
    half_period = qtrk_pkg::PERIOD_RST;
    cfg_min = qtrk_pkg::MIN_INTERVAL_RST;
    cfg_max = qtrk_pkg::MAX_INTERVAL_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every edge and tick command with every pin combination, both directions, direction
    // changes, a half step each way, zero at reset and mid-run.
    begin_phase(16'd2, 16'd8, 29, 75);
    push_item(qtrk_pkg::CMD_ZERO, 1'b0, 1'b0);
    push_item(qtrk_pkg::CMD_TICK, 1'b1, 1'b1);
    push_item(qtrk_pkg::CMD_EDGE_B, 1'b0, 1'b0);
    repeat (3) push_item(qtrk_pkg::CMD_TICK, 1'b0, 1'b1);
    push_item(qtrk_pkg::CMD_EDGE_A, 1'b1, 1'b1);
    repeat (3) push_item(qtrk_pkg::CMD_TICK, 1'b1, 1'b0);
    push_item(qtrk_pkg::CMD_EDGE_A, 1'b0, 1'b0);
    push_item(qtrk_pkg::CMD_EDGE_B, 1'b1, 1'b0);
    push_item(qtrk_pkg::CMD_EDGE_B, 1'b0, 1'b1);
    push_item(qtrk_pkg::CMD_EDGE_A, 1'b1, 1'b0);
    push_item(qtrk_pkg::CMD_EDGE_A, 1'b0, 1'b1);
    push_item(qtrk_pkg::CMD_EDGE_B, 1'b1, 1'b1);
    repeat (2) push_item(qtrk_pkg::CMD_TICK, 1'b0, 1'b0);
    push_item(qtrk_pkg::CMD_ZERO, 1'b1, 1'b1);
    push_item(qtrk_pkg::CMD_EDGE_A, 1'b0, 1'b1);
    repeat (4) push_item(qtrk_pkg::CMD_TICK, 1'b1, 1'b1);
    settle();

    // Narrowest clamps: a half step on the second tick after an edge.
    begin_phase(16'd2, 16'd2, 29, 75);
    gen_random(200, 5);
    settle();

    // Mid-range clamps, with a long output hold-off so the block backs up.
    begin_phase(16'd10, 16'd40, 29, 75);
    gen_random(200, 45);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
    settle();

    // Lower clamp below two: short intervals give a zero period.
    begin_phase(16'd1, 16'd30, 75, 29);
    gen_random(200, 20);
    settle();

    // Crossed clamps: the upper one wins.
    begin_phase(16'd50, 16'd12, 75, 29);
    gen_random(150, 16);
    settle();

    // No clamping at all: the period follows the raw interval.
    begin_phase(16'd0, 16'hFFFF, 75, 29);
    gen_random(200, 30);
    settle();

    // Widest interval: the half step is never reached in short bursts.
    begin_phase(16'hFFFF, 16'hFFFF, 0, 0);
    gen_random(100, 10);
    settle();

    // Back to the reset clamps.
    begin_phase(qtrk_pkg::MIN_INTERVAL_RST, qtrk_pkg::MAX_INTERVAL_RST, 0, 0);
    gen_random(250, 80);
    settle();

    // A raw interval between the clamps, then a short run of steps one way.
    begin_phase(16'd2, 16'd1000, 0, 0);
    push_item(qtrk_pkg::CMD_EDGE_A, 1'b1, 1'b1);
    repeat (20) push_item(qtrk_pkg::CMD_TICK, 1'b0, 1'b0);
    push_item(qtrk_pkg::CMD_EDGE_B, 1'b1, 1'b0);
    repeat (12) push_item(qtrk_pkg::CMD_TICK, 1'b1, 1'b0);
    repeat (10) begin
      if ($urandom_range(0, 1)) push_item(qtrk_pkg::CMD_EDGE_A, 1'b1, 1'b1);
      else push_item(qtrk_pkg::CMD_EDGE_B, 1'b0, 1'b1);
    end
    settle();

    $display("%0d input beats over %0d clamp settings; %0d result beats checked",
             beats_accepted, settings_applied, results_checked);
    $display("including %0d direction changes and %0d half-step reports",
             direction_reports, half_step_reports);
    if (mismatch_count == 0) begin
      $display("quadrature_tracker_with_interpolation_tb: clean");
    end else begin
      $display("quadrature_tracker_with_interpolation_tb: errors");
    end
    $finish;
  end

endmodule
